@@ design/acf_pkg.sv @@
// Shared types, constants and solver microcode for the circle fit block.
`timescale 1ns / 1ps
package acf_pkg;

    // Operand sources for the shared multiply-accumulate
    typedef enum logic [3:0] {
        OPD_N, OPD_SX, OPD_SY, OPD_SXX, OPD_SYY, OPD_SXY, OPD_SZ, OPD_SXZ, OPD_SYZ,
        OPD_MX, OPD_MY
    } t_opnd;

    // Working register file: cofactors and determinants, 128 bits each
    localparam int W_COUNT = 10;
    typedef logic [3:0] t_widx;
    localparam t_widx W_C00 = 4'd0;
    localparam t_widx W_C01 = 4'd1;
    localparam t_widx W_C02 = 4'd2;
    localparam t_widx W_C11 = 4'd3;
    localparam t_widx W_C12 = 4'd4;
    localparam t_widx W_C22 = 4'd5;
    localparam t_widx W_DET = 4'd6;
    localparam t_widx W_DA  = 4'd7;
    localparam t_widx W_DB  = 4'd8;
    localparam t_widx W_DC  = 4'd9;

    typedef struct packed {
        logic  a_w;     // A operand from the register file
        t_opnd a_src;
        t_widx a_reg;
        t_opnd b_src;
        logic  sub;
        logic  first;   // clear accumulator
        logic  last;    // write accumulator back
        t_widx dest;
    } t_mac_step;

    localparam logic [4:0] MAC_DET_END  = 5'd23;
    localparam logic [4:0] MAC_SQ_FIRST = 5'd24;
    localparam logic [4:0] MAC_SQ_END   = 5'd25;

    function automatic t_mac_step mac_s(input t_opnd a, input t_opnd b, input logic sub,
                                        input logic first, input logic last,
                                        input t_widx dest);
        t_mac_step s;
        s.a_w   = 1'b0;
        s.a_src = a;
        s.a_reg = W_C00;
        s.b_src = b;
        s.sub   = sub;
        s.first = first;
        s.last  = last;
        s.dest  = dest;
        return s;
    endfunction

    function automatic t_mac_step mac_w(input t_widx a, input t_opnd b,
                                        input logic first, input logic last,
                                        input t_widx dest);
        t_mac_step s;
        s.a_w   = 1'b1;
        s.a_src = OPD_N;
        s.a_reg = a;
        s.b_src = b;
        s.sub   = 1'b0;
        s.first = first;
        s.last  = last;
        s.dest  = dest;
        return s;
    endfunction

    // Cofactors, then determinant and the three Cramer numerators, then cx^2 + cy^2
    function automatic t_mac_step mac_prog(input logic [4:0] idx);
        t_mac_step s;
        case (idx)
            5'd0:    s = mac_s(OPD_SYY, OPD_N,   1'b0, 1'b1, 1'b0, W_C00);
            5'd1:    s = mac_s(OPD_SY,  OPD_SY,  1'b1, 1'b0, 1'b1, W_C00);
            5'd2:    s = mac_s(OPD_SY,  OPD_SX,  1'b0, 1'b1, 1'b0, W_C01);
            5'd3:    s = mac_s(OPD_SXY, OPD_N,   1'b1, 1'b0, 1'b1, W_C01);
            5'd4:    s = mac_s(OPD_SXY, OPD_SY,  1'b0, 1'b1, 1'b0, W_C02);
            5'd5:    s = mac_s(OPD_SYY, OPD_SX,  1'b1, 1'b0, 1'b1, W_C02);
            5'd6:    s = mac_s(OPD_SXX, OPD_N,   1'b0, 1'b1, 1'b0, W_C11);
            5'd7:    s = mac_s(OPD_SX,  OPD_SX,  1'b1, 1'b0, 1'b1, W_C11);
            5'd8:    s = mac_s(OPD_SXY, OPD_SX,  1'b0, 1'b1, 1'b0, W_C12);
            5'd9:    s = mac_s(OPD_SXX, OPD_SY,  1'b1, 1'b0, 1'b1, W_C12);
            5'd10:   s = mac_s(OPD_SXX, OPD_SYY, 1'b0, 1'b1, 1'b0, W_C22);
            5'd11:   s = mac_s(OPD_SXY, OPD_SXY, 1'b1, 1'b0, 1'b1, W_C22);
            5'd12:   s = mac_w(W_C00, OPD_SXX, 1'b1, 1'b0, W_DET);
            5'd13:   s = mac_w(W_C01, OPD_SXY, 1'b0, 1'b0, W_DET);
            5'd14:   s = mac_w(W_C02, OPD_SX,  1'b0, 1'b1, W_DET);
            5'd15:   s = mac_w(W_C00, OPD_SXZ, 1'b1, 1'b0, W_DA);
            5'd16:   s = mac_w(W_C01, OPD_SYZ, 1'b0, 1'b0, W_DA);
            5'd17:   s = mac_w(W_C02, OPD_SZ,  1'b0, 1'b1, W_DA);
            5'd18:   s = mac_w(W_C01, OPD_SXZ, 1'b1, 1'b0, W_DB);
            5'd19:   s = mac_w(W_C11, OPD_SYZ, 1'b0, 1'b0, W_DB);
            5'd20:   s = mac_w(W_C12, OPD_SZ,  1'b0, 1'b1, W_DB);
            5'd21:   s = mac_w(W_C02, OPD_SXZ, 1'b1, 1'b0, W_DC);
            5'd22:   s = mac_w(W_C12, OPD_SYZ, 1'b0, 1'b0, W_DC);
            5'd23:   s = mac_w(W_C22, OPD_SZ,  1'b0, 1'b1, W_DC);
            5'd24:   s = mac_s(OPD_MX,  OPD_MX,  1'b0, 1'b1, 1'b0, W_C00);
            5'd25:   s = mac_s(OPD_MY,  OPD_MY,  1'b0, 1'b0, 1'b0, W_C00);
            default: s = mac_s(OPD_N,   OPD_N,   1'b0, 1'b1, 1'b0, W_C00);
        endcase
        return s;
    endfunction

    typedef struct packed {
        t_widx      num;
        logic       dbl;      // divide by twice the determinant
        logic [4:0] frac;     // extra quotient bits
        logic       cap_big;  // cap at 2^62 instead of 2^40
    } t_div_step;

    localparam logic [2:0] DIV_CX = 3'd0;
    localparam logic [2:0] DIV_CY = 3'd1;
    localparam logic [2:0] DIV_HX = 3'd2;
    localparam logic [2:0] DIV_HY = 3'd3;
    localparam logic [2:0] DIV_CQ = 3'd4;

    function automatic t_div_step div_prog(input logic [2:0] idx);
        t_div_step d;
        case (idx)
            DIV_CX:  d = '{num: W_DA, dbl: 1'b1, frac: 5'd0,  cap_big: 1'b0};
            DIV_CY:  d = '{num: W_DB, dbl: 1'b1, frac: 5'd0,  cap_big: 1'b0};
            DIV_HX:  d = '{num: W_DA, dbl: 1'b1, frac: 5'd8,  cap_big: 1'b0};
            DIV_HY:  d = '{num: W_DB, dbl: 1'b1, frac: 5'd8,  cap_big: 1'b0};
            DIV_CQ:  d = '{num: W_DC, dbl: 1'b0, frac: 5'd16, cap_big: 1'b1};
            default: d = '{num: W_DA, dbl: 1'b1, frac: 5'd0,  cap_big: 1'b0};
        endcase
        return d;
    endfunction

    localparam logic [63:0] CAP_SMALL = 64'h0000_0100_0000_0000;
    localparam logic [63:0] CAP_BIG   = 64'h4000_0000_0000_0000;
    localparam logic [63:0] FAR_LIMIT = 64'h0000_0000_2000_0000;
    localparam logic [63:0] SQRT_TOP  = 64'h4000_0000_0000_0000;
    localparam logic [15:0] RAD_MAX   = 16'hFFFF;
    localparam logic [7:0]  MAC_LAST_BIT = 8'd63;
    localparam logic [7:0]  SQRT_LAST    = 8'd31;
    localparam logic [7:0]  DIV_BASE     = 8'd127;

    typedef enum logic [1:0] {ST_OK, ST_FEW, ST_SINGULAR, ST_MANY} t_status;

    typedef struct packed {
        logic signed [63:0] n;
        logic signed [63:0] sx;
        logic signed [63:0] sy;
        logic signed [63:0] sxx;
        logic signed [63:0] syy;
        logic signed [63:0] sxy;
        logic signed [63:0] sz;
        logic signed [63:0] sxz;
        logic signed [63:0] syz;
    } t_sums;

    typedef struct packed {
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] rad;
        t_status     status;
    } t_fit;

    typedef enum logic [3:0] {
        S_IDLE, S_MLOAD, S_MRUN, S_MEND, S_CHECK, S_DLOADN, S_DLOADD, S_DRUN, S_DRND,
        S_FAR, S_ADDC, S_SQRT, S_RAD, S_DONE
    } t_sstate;

    typedef enum logic [2:0] {T_IDLE, T_MUL, T_DECIDE, T_SOLVE, T_PUT} t_tstate;

endpackage

@@ design/acf_solver.sv @@
// Sequenced solver: 3x3 normal equations, center division and radius root.
`timescale 1ns / 1ps
module acf_solver (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  acf_pkg::t_sums i_sums,
    output logic           o_done,
    output acf_pkg::t_fit  o_fit
);

    acf_pkg::t_sstate   r_state, n_state;
    logic [4:0]         r_step;
    logic [2:0]         r_div;
    logic [7:0]         r_cnt;
    logic [127:0]       r_acc;   // accumulator, remainder, root operand
    logic [127:0]       r_a;     // multiplicand, dividend
    logic [63:0]        r_b;     // multiplier, root bit
    logic [127:0]       r_d;
    logic [63:0]        r_q;
    logic               r_sat;
    logic               r_neg;
    logic [63:0]        r_root;
    logic [63:0]        r_mx;
    logic [63:0]        r_my;
    logic [63:0]        r_cq_mag;
    logic               r_cq_neg;
    logic [15:0]        r_cx;
    logic [15:0]        r_cy;
    logic [15:0]        r_rad;
    acf_pkg::t_status   r_status;
    logic [127:0]       r_wreg [acf_pkg::W_COUNT];

    acf_pkg::t_mac_step e;
    acf_pkg::t_div_step dv;
    acf_pkg::t_widx     rd_addr;
    logic [127:0]       wreg_rd;
    logic [63:0]        opa;
    logic [63:0]        opb;
    logic [127:0]       add_x;
    logic [127:0]       add_y;
    logic               add_sub;
    logic [128:0]       add_sum;
    logic [127:0]       add_res;
    logic               add_carry;
    logic [127:0]       den;
    logic [127:0]       rem_sh;
    logic [63:0]        q_sh;
    logic [63:0]        cap;
    logic [63:0]        q_inc;
    logic [63:0]        q_fin;
    logic               sat_fin;
    logic [63:0]        res_mag;
    logic [15:0]        clamp_v;
    logic [63:0]        sq_t;
    logic [63:0]        rad_full;
    logic [7:0]         div_end;

    assign e  = acf_pkg::mac_prog(r_step);
    assign dv = acf_pkg::div_prog(r_div);
    assign cap = dv.cap_big ? acf_pkg::CAP_BIG : acf_pkg::CAP_SMALL;
    assign div_end = acf_pkg::DIV_BASE + 8'(dv.frac);

    always_comb begin
        case (r_state)
            acf_pkg::S_MLOAD:  rd_addr = e.a_reg;
            acf_pkg::S_DLOADN: rd_addr = dv.num;
            default:           rd_addr = acf_pkg::W_DET;
        endcase
    end
    assign wreg_rd = r_wreg[rd_addr];

    always_comb begin
        case (e.a_src)
            acf_pkg::OPD_N:   opa = i_sums.n;
            acf_pkg::OPD_SX:  opa = i_sums.sx;
            acf_pkg::OPD_SY:  opa = i_sums.sy;
            acf_pkg::OPD_SXX: opa = i_sums.sxx;
            acf_pkg::OPD_SYY: opa = i_sums.syy;
            acf_pkg::OPD_SXY: opa = i_sums.sxy;
            acf_pkg::OPD_SZ:  opa = i_sums.sz;
            acf_pkg::OPD_SXZ: opa = i_sums.sxz;
            acf_pkg::OPD_SYZ: opa = i_sums.syz;
            acf_pkg::OPD_MX:  opa = r_mx;
            acf_pkg::OPD_MY:  opa = r_my;
            default:          opa = '0;
        endcase
        case (e.b_src)
            acf_pkg::OPD_N:   opb = i_sums.n;
            acf_pkg::OPD_SX:  opb = i_sums.sx;
            acf_pkg::OPD_SY:  opb = i_sums.sy;
            acf_pkg::OPD_SXX: opb = i_sums.sxx;
            acf_pkg::OPD_SYY: opb = i_sums.syy;
            acf_pkg::OPD_SXY: opb = i_sums.sxy;
            acf_pkg::OPD_SZ:  opb = i_sums.sz;
            acf_pkg::OPD_SXZ: opb = i_sums.sxz;
            acf_pkg::OPD_SYZ: opb = i_sums.syz;
            acf_pkg::OPD_MX:  opb = r_mx;
            acf_pkg::OPD_MY:  opb = r_my;
            default:          opb = '0;
        endcase
    end

    assign den    = dv.dbl ? {wreg_rd[126:0], 1'b0} : wreg_rd;
    assign rem_sh = {r_acc[126:0], r_a[127]};
    assign sq_t   = r_root + r_b;

    // One 128-bit adder serves the multiply, divide, center-add and root steps
    always_comb begin
        add_x   = '0;
        add_y   = '0;
        add_sub = 1'b1;
        case (r_state)
            acf_pkg::S_MRUN: begin
                add_x   = r_acc;
                add_y   = r_a;
                add_sub = e.sub ^ (r_cnt == acf_pkg::MAC_LAST_BIT);
            end
            acf_pkg::S_DLOADN: add_y = wreg_rd;
            acf_pkg::S_DLOADD: add_y = den;
            acf_pkg::S_DRUN: begin
                add_x = rem_sh;
                add_y = r_d;
            end
            acf_pkg::S_DRND: begin
                add_x = {r_acc[126:0], 1'b0};
                add_y = r_d;
            end
            acf_pkg::S_ADDC: begin
                add_x   = r_acc;
                add_y   = {64'd0, r_cq_mag};
                add_sub = r_cq_neg;
            end
            acf_pkg::S_SQRT: begin
                add_x = {64'd0, r_acc[63:0]};
                add_y = {64'd0, sq_t};
            end
            default: ;
        endcase
    end
    assign add_sum   = {1'b0, add_x} + {1'b0, add_y ^ {128{add_sub}}} + 129'(add_sub);
    assign add_res   = add_sum[127:0];
    assign add_carry = add_sum[128];

    assign q_sh    = {r_q[62:0], add_carry};
    assign q_inc   = r_q + 64'd1;
    assign q_fin   = (!r_sat && add_carry) ? q_inc : r_q;
    assign sat_fin = r_sat || (add_carry && (q_inc > cap));
    assign res_mag = (r_d == '0) ? 64'd0 : (sat_fin ? cap : q_fin);

    // Saturate the signed quotient to 16 bits
    always_comb begin
        if (!r_neg) begin
            clamp_v = (res_mag > 64'd32767) ? 16'h7FFF : res_mag[15:0];
        end else begin
            clamp_v = (res_mag > 64'd32768) ? 16'h8000 : 16'(16'd0 - res_mag[15:0]);
        end
    end

    assign rad_full = (r_root + 64'd128) >> 8;

    always_comb begin
        n_state = r_state;
        case (r_state)
            acf_pkg::S_IDLE:   if (i_start) n_state = acf_pkg::S_MLOAD;
            acf_pkg::S_MLOAD:  n_state = acf_pkg::S_MRUN;
            acf_pkg::S_MRUN:   if (r_cnt == acf_pkg::MAC_LAST_BIT) n_state = acf_pkg::S_MEND;
            acf_pkg::S_MEND: begin
                if (r_step == acf_pkg::MAC_DET_END) begin
                    n_state = acf_pkg::S_CHECK;
                end else if (r_step == acf_pkg::MAC_SQ_END) begin
                    n_state = acf_pkg::S_ADDC;
                end else begin
                    n_state = acf_pkg::S_MLOAD;
                end
            end
            acf_pkg::S_CHECK:  n_state = (wreg_rd == '0) ? acf_pkg::S_DONE : acf_pkg::S_DLOADN;
            acf_pkg::S_DLOADN: n_state = acf_pkg::S_DLOADD;
            acf_pkg::S_DLOADD: n_state = acf_pkg::S_DRUN;
            acf_pkg::S_DRUN:   if (r_cnt == div_end) n_state = acf_pkg::S_DRND;
            acf_pkg::S_DRND: begin
                if (r_div == acf_pkg::DIV_HY) begin
                    n_state = acf_pkg::S_FAR;
                end else if (r_div == acf_pkg::DIV_CQ) begin
                    n_state = acf_pkg::S_MLOAD;
                end else begin
                    n_state = acf_pkg::S_DLOADN;
                end
            end
            acf_pkg::S_FAR: begin
                if (r_mx > acf_pkg::FAR_LIMIT || r_my > acf_pkg::FAR_LIMIT) begin
                    n_state = acf_pkg::S_DONE;
                end else begin
                    n_state = acf_pkg::S_DLOADN;
                end
            end
            acf_pkg::S_ADDC:   n_state = acf_pkg::S_SQRT;
            acf_pkg::S_SQRT:   if (r_cnt == acf_pkg::SQRT_LAST) n_state = acf_pkg::S_RAD;
            acf_pkg::S_RAD:    n_state = acf_pkg::S_DONE;
            acf_pkg::S_DONE:   n_state = acf_pkg::S_IDLE;
            default:           n_state = acf_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= acf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            acf_pkg::S_IDLE: begin
                r_step   <= '0;
                r_div    <= '0;
                r_cx     <= '0;
                r_cy     <= '0;
                r_rad    <= '0;
                r_status <= acf_pkg::ST_OK;
            end
            acf_pkg::S_MLOAD: begin
                r_a   <= e.a_w ? wreg_rd : {{64{opa[63]}}, opa};
                r_b   <= opb;
                r_cnt <= '0;
                if (e.first) r_acc <= '0;
            end
            acf_pkg::S_MRUN: begin
                if (r_b[0]) r_acc <= add_res;
                r_a   <= {r_a[126:0], 1'b0};
                r_b   <= {1'b0, r_b[63:1]};
                r_cnt <= r_cnt + 8'd1;
            end
            acf_pkg::S_MEND: begin
                if (e.last) r_wreg[e.dest] <= r_acc;
                if (r_step != acf_pkg::MAC_DET_END && r_step != acf_pkg::MAC_SQ_END) begin
                    r_step <= r_step + 5'd1;
                end
            end
            acf_pkg::S_CHECK: begin
                if (wreg_rd == '0) r_status <= acf_pkg::ST_SINGULAR;
            end
            acf_pkg::S_DLOADN: begin
                r_a   <= wreg_rd[127] ? add_res : wreg_rd;
                r_neg <= wreg_rd[127];
            end
            acf_pkg::S_DLOADD: begin
                r_d   <= den[127] ? add_res : den;
                r_neg <= r_neg ^ den[127];
                r_acc <= '0;
                r_q   <= '0;
                r_sat <= 1'b0;
                r_cnt <= '0;
            end
            acf_pkg::S_DRUN: begin
                r_acc <= add_carry ? add_res : rem_sh;
                r_a   <= {r_a[126:0], 1'b0};
                if (!r_sat) begin
                    r_q <= q_sh;
                    if (q_sh > cap) r_sat <= 1'b1;
                end
                r_cnt <= r_cnt + 8'd1;
            end
            acf_pkg::S_DRND: begin
                case (r_div)
                    acf_pkg::DIV_CX: r_cx <= clamp_v;
                    acf_pkg::DIV_CY: r_cy <= clamp_v;
                    acf_pkg::DIV_HX: r_mx <= res_mag;
                    acf_pkg::DIV_HY: r_my <= res_mag;
                    default: begin
                        r_cq_mag <= res_mag;
                        r_cq_neg <= r_neg;
                    end
                endcase
                if (r_div != acf_pkg::DIV_HY) r_div <= r_div + 3'd1;
                if (r_div == acf_pkg::DIV_CQ) r_step <= acf_pkg::MAC_SQ_FIRST;
            end
            acf_pkg::S_FAR: begin
                r_div <= acf_pkg::DIV_CQ;
                if (r_mx > acf_pkg::FAR_LIMIT || r_my > acf_pkg::FAR_LIMIT) begin
                    r_rad <= acf_pkg::RAD_MAX;
                end
            end
            acf_pkg::S_ADDC: begin
                // clamp a negative radius square at zero
                r_acc  <= add_res[127] ? '0 : {64'd0, add_res[63:0]};
                r_root <= '0;
                r_b    <= acf_pkg::SQRT_TOP;
                r_cnt  <= '0;
            end
            acf_pkg::S_SQRT: begin
                if (add_carry) begin
                    r_acc[63:0] <= add_res[63:0];
                    r_root      <= {1'b0, r_root[63:1]} + r_b;
                end else begin
                    r_root <= {1'b0, r_root[63:1]};
                end
                r_b   <= {2'b00, r_b[63:2]};
                r_cnt <= r_cnt + 8'd1;
            end
            acf_pkg::S_RAD: begin
                r_rad <= (rad_full[63:16] != '0) ? acf_pkg::RAD_MAX : rad_full[15:0];
            end
            default: ;
        endcase
    end

    assign o_done       = (r_state == acf_pkg::S_DONE);
    assign o_fit.cx     = r_cx;
    assign o_fit.cy     = r_cy;
    assign o_fit.rad    = r_rad;
    assign o_fit.status = r_status;

endmodule

@@ design/algebraic_circle_fit_top.sv @@
// Top level of the algebraic least-squares circle fit: point intake, sums, result beat.
`timescale 1ns / 1ps
// Usage:
//   Points arrive on the s_axis channel, one beat per point: tdata carries x in
//   [15:0] and y in [31:16], both signed Q4.11; tlast marks the final point of a set.
//   Each point is accumulated through one shared 16x33 multiplier, so the block
//   takes no new point until the last one has been accumulated.
//   A set ends with the tlast beat. With enough points the shared 128-bit
//   adder solves the normal equations (26 multiply-accumulates), runs up to
//   five restoring divisions and a 32-step root. Too few points or an
//   overflowed count returns a result without running the solver.
//   The result beat on m_axis carries center x [15:0], center y [31:16] and
//   radius [47:32] in tdata, status in tuser. Every tlast beat gives one result.
//   A result waits in the output register while the receiver stalls; the block
//   keeps taking points meanwhile, and holds a new result until the register drains.
//   The cfg channel writes min_points and is always ready; write it while idle.
//   Reset clears the sums, the count and the output valid flag, and sets min_points to 4.
module algebraic_circle_fit_top #(
    parameter int MAX_POINTS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // point_x, point_y
    input  logic        s_axis_tlast,   // last_point
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // center_x, center_y, radius
    output logic [1:0]  m_axis_tuser,   // status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [10:0] i_cfg_data      // min_points
);

    localparam int LOG_N  = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int SX_W   = 16 + LOG_N;
    localparam int SXX_W  = 32 + LOG_N;
    localparam int SZ_W   = 33 + LOG_N;
    localparam int SXZ_W  = 48 + LOG_N;
    localparam int CMP_W  = (CNT_W > 11) ? CNT_W : 11;

    acf_pkg::t_tstate          r_state, n_state;
    logic [2:0]                r_k;
    logic [10:0]               r_min;
    logic [CNT_W-1:0]          r_count;
    logic                      r_ovf;
    logic signed [15:0]        r_x;
    logic signed [15:0]        r_y;
    logic                      r_last;
    logic [31:0]               r_z;
    logic signed [48:0]        r_prod;
    logic signed [SX_W-1:0]    r_sum_x;
    logic signed [SX_W-1:0]    r_sum_y;
    logic signed [SXX_W-1:0]   r_sum_xx;
    logic signed [SXX_W-1:0]   r_sum_yy;
    logic signed [SXX_W-1:0]   r_sum_xy;
    logic signed [SZ_W-1:0]    r_sum_z;
    logic signed [SXZ_W-1:0]   r_sum_xz;
    logic signed [SXZ_W-1:0]   r_sum_yz;
    acf_pkg::t_fit             r_res;
    acf_pkg::t_fit             r_out;
    logic                      r_out_valid;

    logic                      in_beat;
    logic                      out_free;
    logic                      fit_ok;
    logic                      solve_start;
    logic                      solve_done;
    acf_pkg::t_fit             solve_fit;
    acf_pkg::t_sums            sums;
    logic signed [15:0]        mul_a;
    logic signed [32:0]        mul_b;
    logic signed [48:0]        mul_p;

    assign s_axis_tready = (r_state == acf_pkg::T_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign fit_ok        = !r_ovf && (CMP_W'(r_count) >= CMP_W'(r_min));
    assign solve_start   = (r_state == acf_pkg::T_DECIDE) && fit_ok;

    // Multiplier operand order: xx, yy, xy, xz, yz
    always_comb begin
        case (r_k)
            3'd0:    begin mul_a = r_x; mul_b = 33'(r_x); end
            3'd1:    begin mul_a = r_y; mul_b = 33'(r_y); end
            3'd2:    begin mul_a = r_x; mul_b = 33'(r_y); end
            3'd3:    begin mul_a = r_x; mul_b = $signed({1'b0, r_z}); end
            3'd4:    begin mul_a = r_y; mul_b = $signed({1'b0, r_z}); end
            default: begin mul_a = r_y; mul_b = $signed({1'b0, r_z}); end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_comb begin
        n_state = r_state;
        case (r_state)
            acf_pkg::T_IDLE: begin
                if (in_beat) begin
                    if (!r_ovf && r_count < CNT_W'(MAX_POINTS)) begin
                        n_state = acf_pkg::T_MUL;
                    end else if (s_axis_tlast) begin
                        n_state = acf_pkg::T_DECIDE;
                    end
                end
            end
            acf_pkg::T_MUL: begin
                if (r_k == 3'd5) n_state = r_last ? acf_pkg::T_DECIDE : acf_pkg::T_IDLE;
            end
            acf_pkg::T_DECIDE: n_state = fit_ok ? acf_pkg::T_SOLVE : acf_pkg::T_PUT;
            acf_pkg::T_SOLVE:  if (solve_done) n_state = acf_pkg::T_PUT;
            acf_pkg::T_PUT:    if (out_free) n_state = acf_pkg::T_IDLE;
            default:           n_state = acf_pkg::T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= acf_pkg::T_IDLE;
            r_min       <= 11'd4;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_sum_xx    <= '0;
            r_sum_yy    <= '0;
            r_sum_xy    <= '0;
            r_sum_z     <= '0;
            r_sum_xz    <= '0;
            r_sum_yz    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_min <= i_cfg_data;

            // load a new result beat, or drop the old one once taken
            if (r_state == acf_pkg::T_PUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                acf_pkg::T_IDLE: begin
                    if (in_beat) begin
                        r_x    <= s_axis_tdata[15:0];
                        r_y    <= s_axis_tdata[31:16];
                        r_last <= s_axis_tlast;
                        r_k    <= '0;
                        // drop points past the limit and flag the set
                        if (!r_ovf && r_count >= CNT_W'(MAX_POINTS)) r_ovf <= 1'b1;
                    end
                end
                acf_pkg::T_MUL: begin
                    r_prod <= mul_p;
                    r_k    <= r_k + 3'd1;
                    case (r_k)
                        3'd1: begin
                            r_sum_xx <= r_sum_xx + SXX_W'(r_prod);
                            r_z      <= r_prod[31:0];
                        end
                        3'd2: begin
                            r_sum_yy <= r_sum_yy + SXX_W'(r_prod);
                            r_z      <= r_z + r_prod[31:0];
                        end
                        3'd3: begin
                            r_sum_xy <= r_sum_xy + SXX_W'(r_prod);
                            r_sum_z  <= r_sum_z + SZ_W'({1'b0, r_z});
                        end
                        3'd4: r_sum_xz <= r_sum_xz + SXZ_W'(r_prod);
                        3'd5: begin
                            r_sum_yz <= r_sum_yz + SXZ_W'(r_prod);
                            r_sum_x  <= r_sum_x + SX_W'(r_x);
                            r_sum_y  <= r_sum_y + SX_W'(r_y);
                            r_count  <= r_count + CNT_W'(1);
                        end
                        default: ;
                    endcase
                end
                acf_pkg::T_DECIDE: begin
                    r_res.cx     <= '0;
                    r_res.cy     <= '0;
                    r_res.rad    <= '0;
                    r_res.status <= r_ovf ? acf_pkg::ST_MANY : acf_pkg::ST_FEW;
                end
                acf_pkg::T_SOLVE: begin
                    if (solve_done) r_res <= solve_fit;
                end
                acf_pkg::T_PUT: begin
                    if (out_free) begin
                        r_out       <= r_res;
                        // clear the set for the next run of points
                        r_count     <= '0;
                        r_ovf       <= 1'b0;
                        r_sum_x     <= '0;
                        r_sum_y     <= '0;
                        r_sum_xx    <= '0;
                        r_sum_yy    <= '0;
                        r_sum_xy    <= '0;
                        r_sum_z     <= '0;
                        r_sum_xz    <= '0;
                        r_sum_yz    <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign sums.n   = 64'(r_count);
    assign sums.sx  = 64'(r_sum_x);
    assign sums.sy  = 64'(r_sum_y);
    assign sums.sxx = 64'(r_sum_xx);
    assign sums.syy = 64'(r_sum_yy);
    assign sums.sxy = 64'(r_sum_xy);
    assign sums.sz  = 64'(r_sum_z);
    assign sums.sxz = 64'(r_sum_xz);
    assign sums.syz = 64'(r_sum_yz);

    acf_solver u_solver (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (solve_start),
        .i_sums  (sums),
        .o_done  (solve_done),
        .o_fit   (solve_fit)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.rad, r_out.cy, r_out.cx};
    assign m_axis_tuser  = r_out.status;

endmodule
